@@ src/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check an expression on every clock edge outside reset
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// check a consequent in the same cycle as its antecedent
`define ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// check a consequent in the cycle after its antecedent
`define ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/atc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package atc_pkg;

  localparam int WINDOW_DEF      = 100;
  localparam int SAMPLE_BITS_DEF = 10;

  localparam int NSP_W      = 8;
  localparam int OFF_W      = 8;
  localparam int SP_W       = 10;
  localparam int AVG_W      = 11;
  localparam int ACT_W      = 2;
  localparam int IN_FIXED_W = NSP_W + 3;
  localparam int OUT_DW     = 32;

  localparam logic signed [SP_W-1:0] SP_RESET = 10'sd72;
  localparam logic signed [SP_W-1:0] SP_MAX   = 10'sd511;
  localparam logic signed [SP_W-1:0] SP_MIN   = -10'sd512;

  localparam int AVG_MAX = 1023;
  localparam int AVG_MIN = -1024;

  typedef enum logic [ACT_W-1:0] {
    ACT_TICK = 2'd0,
    ACT_POLL = 2'd1,
    ACT_LOAD = 2'd2
  } act_t;

endpackage

`default_nettype wire

@@ src/atc_avg.sv @@
`timescale 1ns / 1ps
`default_nettype none

module atc_avg #(
  parameter int WINDOW      = atc_pkg::WINDOW_DEF,
  parameter int SAMPLE_BITS = atc_pkg::SAMPLE_BITS_DEF,
  localparam int SUM_W      = SAMPLE_BITS + $clog2(WINDOW) + 1,
  localparam int Q_W        = SAMPLE_BITS + 3
) (
  input  logic                    clk,
  input  logic                    load,
  input  logic signed [SUM_W-1:0] sum,
  output logic signed [Q_W-1:0]   quot
);

  localparam int LOG_W  = $clog2(WINDOW);
  localparam int MAG_W  = SUM_W;
  localparam int K      = MAG_W + LOG_W;
  localparam int PROD_W = 2 * MAG_W + 1;
  localparam logic [63:0] RECIP64 =
    ((64'd1 << K) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam logic [MAG_W:0] RECIP = RECIP64[MAG_W:0];

  logic [MAG_W-1:0]       mag;
  logic [PROD_W-1:0]      prod_r;
  logic                   neg_r;
  logic [SAMPLE_BITS+1:0] qmag;

  always_comb begin
    mag = sum[SUM_W-1] ? MAG_W'(-sum) : MAG_W'(sum);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= PROD_W'(mag) * PROD_W'(RECIP);
      neg_r  <= sum[SUM_W-1];
    end
  end

  // truncate toward zero: divide the magnitude, then restore the sign
  always_comb begin
    qmag = prod_r[PROD_W-1:K];
    quot = neg_r ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
  end

endmodule

`default_nettype wire

@@ src/averaging_thermostat_controller.sv @@
// A request passes stages s1, s2, s3 and the output register before out_tdata.
// Throughput: one request per cycle while the output is not stalled; the store
// reads the oldest entry at accept; its second port writes the sample leaving s1.
// Reset (synchronous, rst_n low): empty pipeline, sum and fill flag cleared,
// setpoint 72, fan on, offset 0; the store needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module averaging_thermostat_controller #(
  parameter int WINDOW      = atc_pkg::WINDOW_DEF,
  parameter int SAMPLE_BITS = atc_pkg::SAMPLE_BITS_DEF,
  localparam int IN_DW      = ((SAMPLE_BITS + atc_pkg::IN_FIXED_W + 7) / 8) * 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // sample, pin_a, pin_b, button, new_setpoint
  input  logic [IN_DW-1:0]              in_tdata,
  // action
  input  logic [atc_pkg::ACT_W-1:0]     in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // heat_on, cool_on, fan_on, average_temp, setpoint, powered_off
  output logic [atc_pkg::OUT_DW-1:0]    out_tdata,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [atc_pkg::OFF_W-1:0]     cfg_data
);

  import atc_pkg::*;

  localparam int IDX_W = $clog2(WINDOW);
  localparam int SUM_W = SAMPLE_BITS + $clog2(WINDOW) + 1;
  localparam int Q_W   = SAMPLE_BITS + 3;
  localparam int EXT_W = SAMPLE_BITS + 4;
  localparam logic signed [EXT_W-1:0] AVG_MAX_X = EXT_W'(AVG_MAX);
  localparam logic signed [EXT_W-1:0] AVG_MIN_X = EXT_W'(AVG_MIN);

  typedef struct packed {
    act_t                    act;
    logic                    pin_a;
    logic                    pin_b;
    logic                    button;
    logic signed [NSP_W-1:0] new_sp;
  } ctl_t;

  // memory and window
  logic signed [SAMPLE_BITS-1:0] mem [WINDOW];
  logic signed [SAMPLE_BITS-1:0] rd_r;
  logic [IDX_W-1:0]              wr_idx_r;
  logic                          full_r;
  logic signed [SUM_W-1:0]       sum_r;

  // pipeline
  logic                          s1_v_r, s2_v_r, s3_v_r, out_v_r;
  ctl_t                          in_ctl, s1_ctl_r, s2_ctl_r, s3_ctl_r;
  logic signed [SAMPLE_BITS-1:0] s1_smp_r;
  logic [IDX_W-1:0]              s1_idx_r;
  logic                          s1_old_ok_r;
  logic                          adv_out, free1, free2, free3, mv1, mv2, mv3, acc;
  logic                          in_tick;
  logic signed [SAMPLE_BITS-1:0] old_smp;
  logic signed [SUM_W-1:0]       sum_nxt;
  logic signed [Q_W-1:0]         quot;

  // controller state
  logic signed [OFF_W-1:0]       offset_r;
  logic signed [AVG_W-1:0]       avg_r, avg_nxt;
  logic signed [SP_W-1:0]        target_r, target_nxt;
  logic                          last_a_r, last_a_nxt;
  logic                          pwr_off_r, pwr_off_nxt;
  logic                          heat_r, heat_nxt;
  logic                          cool_r, cool_nxt;
  logic                          fan_r, fan_nxt;
  logic signed [EXT_W-1:0]       avg_sum;

  // handshake and pipeline advance
  always_comb begin
    adv_out   = !out_v_r || out_tready;
    mv3       = s3_v_r && adv_out;
    free3     = !s3_v_r || adv_out;
    mv2       = s2_v_r && free3;
    free2     = !s2_v_r || free3;
    mv1       = s1_v_r && free2;
    free1     = !s1_v_r || free2;
    in_tready = free1;
    acc       = in_tvalid && free1;
    cfg_ready = 1'b1;
  end

  always_comb begin
    in_ctl.act    = act_t'(in_tuser);
    in_ctl.pin_a  = in_tdata[SAMPLE_BITS];
    in_ctl.pin_b  = in_tdata[SAMPLE_BITS+1];
    in_ctl.button = in_tdata[SAMPLE_BITS+2];
    in_ctl.new_sp = $signed(in_tdata[SAMPLE_BITS+3 +: NSP_W]);
    in_tick       = (in_ctl.act == ACT_TICK);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (acc) begin
        s1_v_r <= 1'b1;
      end else if (mv1) begin
        s1_v_r <= 1'b0;
      end
      if (mv1) begin
        s2_v_r <= 1'b1;
      end else if (mv2) begin
        s2_v_r <= 1'b0;
      end
      if (mv2) begin
        s3_v_r <= 1'b1;
      end else if (mv3) begin
        s3_v_r <= 1'b0;
      end
      if (mv3) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_ctl_r    <= in_ctl;
      s1_smp_r    <= $signed(in_tdata[SAMPLE_BITS-1:0]);
      s1_idx_r    <= wr_idx_r;
      s1_old_ok_r <= full_r;
    end
    if (mv1) begin
      s2_ctl_r <= s1_ctl_r;
    end
    if (mv2) begin
      s3_ctl_r <= s2_ctl_r;
    end
  end

  // sample store: read the oldest entry at accept of a tick, write the new sample as it leaves s1
  always_ff @(posedge clk) begin
    if (acc && in_tick) begin
      rd_r <= mem[wr_idx_r];
    end
    if (mv1 && s1_ctl_r.act == ACT_TICK) begin
      mem[s1_idx_r] <= s1_smp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r <= '0;
      full_r   <= 1'b0;
    end else if (acc && in_tick) begin
      if (wr_idx_r == IDX_W'(WINDOW - 1)) begin
        wr_idx_r <= '0;
        full_r   <= 1'b1;
      end else begin
        wr_idx_r <= wr_idx_r + 1'b1;
      end
    end
  end

  always_comb begin
    old_smp = s1_old_ok_r ? rd_r : '0;
    sum_nxt = sum_r - SUM_W'(old_smp) + SUM_W'(s1_smp_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (mv1 && s1_ctl_r.act == ACT_TICK) begin
      sum_r <= sum_nxt;
    end
  end

  atc_avg #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_avg (
    .clk  (clk),
    .load (mv2),
    .sum  (sum_r),
    .quot (quot)
  );

  // final stage: drives, knob, setpoint load, power and average
  always_comb begin
    avg_sum     = EXT_W'(quot) + EXT_W'(offset_r);
    avg_nxt     = avg_r;
    target_nxt  = target_r;
    last_a_nxt  = last_a_r;
    pwr_off_nxt = pwr_off_r;
    heat_nxt    = heat_r;
    cool_nxt    = cool_r;
    fan_nxt     = fan_r;
    case (s3_ctl_r.act)
      ACT_TICK: begin
        if (pwr_off_r) begin
          heat_nxt = 1'b0;
          cool_nxt = 1'b0;
          fan_nxt  = 1'b0;
        end else begin
          fan_nxt  = 1'b1;
          heat_nxt = AVG_W'(target_r) > avg_r;
          cool_nxt = AVG_W'(target_r) < avg_r;
        end
        if (avg_sum > AVG_MAX_X) begin
          avg_nxt = AVG_W'(AVG_MAX_X);
        end else if (avg_sum < AVG_MIN_X) begin
          avg_nxt = AVG_W'(AVG_MIN_X);
        end else begin
          avg_nxt = AVG_W'(avg_sum);
        end
      end
      ACT_POLL: begin
        if (s3_ctl_r.button) begin
          pwr_off_nxt = !pwr_off_r;
        end else if (s3_ctl_r.pin_a != last_a_r) begin
          if (s3_ctl_r.pin_a) begin
            if (!s3_ctl_r.pin_b) begin
              if (target_r != SP_MIN) begin
                target_nxt = target_r - 1'b1;
              end
            end else if (target_r != SP_MAX) begin
              target_nxt = target_r + 1'b1;
            end
          end
          last_a_nxt = s3_ctl_r.pin_a;
        end
      end
      ACT_LOAD: begin
        target_nxt = SP_W'(s3_ctl_r.new_sp);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_r     <= '0;
      target_r  <= SP_RESET;
      last_a_r  <= 1'b1;
      pwr_off_r <= 1'b0;
      heat_r    <= 1'b0;
      cool_r    <= 1'b0;
      fan_r     <= 1'b1;
    end else if (mv3) begin
      avg_r     <= avg_nxt;
      target_r  <= target_nxt;
      last_a_r  <= last_a_nxt;
      pwr_off_r <= pwr_off_nxt;
      heat_r    <= heat_nxt;
      cool_r    <= cool_nxt;
      fan_r     <= fan_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      offset_r <= $signed(cfg_data);
    end
  end

  // state changes only when a result loads, so it doubles as the output register
  always_comb begin
    out_tvalid = out_v_r;
    out_tdata  = OUT_DW'({pwr_off_r, target_r, avg_r, fan_r, cool_r, heat_r});
  end

`include "assert_macros.svh"

  `ASSERT_ALWAYS(a_drive_excl, !(heat_r && cool_r), "heat and cool both on")
  `ASSERT_ALWAYS(a_idx_range, 32'(wr_idx_r) < 32'(WINDOW), "write index beyond window")
  `ASSERT_IMP(a_out_src, $rose(out_tvalid), $past(s3_v_r), "result without a staged request")
  `ASSERT_NXT(a_off_tick, mv3 && pwr_off_r && s3_ctl_r.act == ACT_TICK,
    !heat_r && !cool_r && !fan_r, "drive on after power-off tick")

endmodule

`default_nettype wire
